// ===== hdl/lspc_pkg.sv =====
package lspc_pkg;

    localparam int unsigned CFG_DATA_BITS  = 16;
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam int unsigned CODE_BITS      = 5;
    localparam int unsigned LED_COUNT      = 4;

    // item functions
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_SET    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOW = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FAST = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SYNC = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE = 2'd3;

    localparam logic [CFG_DATA_BITS-1:0] SLOW_RESET = 16'd500;
    localparam logic [CFG_DATA_BITS-1:0] FAST_RESET = 16'd100;
    localparam logic [CFG_DATA_BITS-1:0] SYNC_RESET = 16'd250;
    localparam logic [CFG_DATA_BITS-1:0] MODE_RESET = 16'd1000;

    localparam logic [CODE_BITS-1:0] PATTERN_CLEARED = 5'd0;
    localparam logic [CODE_BITS-1:0] PATTERN_LAST    = 5'd16;

    // led bits: green, yellow, red, blue
    localparam logic [LED_COUNT-1:0] LED_NONE = 4'b0000;
    localparam logic [LED_COUNT-1:0] LED_G    = 4'b0001;
    localparam logic [LED_COUNT-1:0] LED_Y    = 4'b0010;
    localparam logic [LED_COUNT-1:0] LED_R    = 4'b0100;
    localparam logic [LED_COUNT-1:0] LED_B    = 4'b1000;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_SLOW,
        SEL_FAST,
        SEL_SYNC,
        SEL_MODE
    } blink_sel_t;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] slow_ms;
        logic [CFG_DATA_BITS-1:0] fast_ms;
        logic [CFG_DATA_BITS-1:0] sync_ms;
        logic [CFG_DATA_BITS-1:0] mode_ms;
    } blink_cfg_t;

    function automatic logic [LED_COUNT-1:0] start_leds(input logic [CODE_BITS-1:0] code);
        logic [LED_COUNT-1:0] leds;
        case (code)
            5'd1, 5'd8, 5'd16:        leds = LED_G;
            5'd2, 5'd3, 5'd9, 5'd15:  leds = LED_Y;
            5'd4, 5'd5, 5'd6:         leds = LED_R;
            5'd7:                     leds = LED_R | LED_Y;
            5'd10, 5'd11, 5'd12, 5'd14: leds = LED_B;
            default:                  leds = LED_NONE;
        endcase
        return leds;
    endfunction

    function automatic blink_sel_t blink_sel(input logic [CODE_BITS-1:0] code);
        blink_sel_t sel;
        case (code)
            5'd3, 5'd5, 5'd9, 5'd11: sel = SEL_SLOW;
            5'd6:                    sel = SEL_FAST;
            5'd8:                    sel = SEL_SYNC;
            5'd14:                   sel = SEL_MODE;
            default:                 sel = SEL_NONE;
        endcase
        return sel;
    endfunction

    function automatic logic [LED_COUNT-1:0] blink_led(input logic [CODE_BITS-1:0] code);
        logic [LED_COUNT-1:0] leds;
        case (code)
            5'd3, 5'd9:   leds = LED_Y;
            5'd5, 5'd6:   leds = LED_R;
            5'd8:         leds = LED_G;
            5'd11, 5'd14: leds = LED_B;
            default:      leds = LED_NONE;
        endcase
        return leds;
    endfunction

endpackage

// ===== hdl/lspc_cfg_regs.sv =====
module lspc_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lspc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [lspc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output lspc_pkg::blink_cfg_t                  intervals
);
    import lspc_pkg::*;

    blink_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign intervals = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_ms <= SLOW_RESET;
            cfg_reg.fast_ms <= FAST_RESET;
            cfg_reg.sync_ms <= SYNC_RESET;
            cfg_reg.mode_ms <= MODE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SLOW: cfg_reg.slow_ms <= cfg_data;
                CFG_FAST: cfg_reg.fast_ms <= cfg_data;
                CFG_SYNC: cfg_reg.sync_ms <= cfg_data;
                CFG_MODE: cfg_reg.mode_ms <= cfg_data;
                default:  cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== hdl/lspc_engine.sv =====
module lspc_engine #(
    parameter int unsigned TIME_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               fire,
    input  logic [1:0]                         func,
    input  logic [lspc_pkg::CODE_BITS-1:0]     code,
    input  logic [TIME_BITS-1:0]               hold,
    input  lspc_pkg::blink_cfg_t               intervals,
    output logic [lspc_pkg::LED_COUNT-1:0]     led_next,
    output logic [lspc_pkg::CODE_BITS-1:0]     pattern_next
);
    import lspc_pkg::*;

    localparam int unsigned CNT_BITS = TIME_BITS + 1;
    localparam int unsigned CMP_BITS = (CNT_BITS > CFG_DATA_BITS) ? CNT_BITS : CFG_DATA_BITS;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    logic [CODE_BITS-1:0] pattern_reg;
    logic [TIME_BITS-1:0] hold_reg,         hold_next;
    logic                 timed_reg,        timed_next;
    logic [CNT_BITS-1:0]  since_start_reg,  since_start_next;
    logic [CNT_BITS-1:0]  since_toggle_reg, since_toggle_next;
    logic                 phase_reg,        phase_next;
    logic [LED_COUNT-1:0] led_reg;

    logic [CNT_BITS-1:0]      start_inc;
    logic [CNT_BITS-1:0]      toggle_inc;
    logic [CODE_BITS-1:0]     set_code;
    blink_sel_t               sel;
    logic [CFG_DATA_BITS-1:0] interval;
    logic [LED_COUNT-1:0]     blink_mask;

    assign start_inc  = (since_start_reg == CNT_MAX) ? since_start_reg : since_start_reg + 1'b1;
    assign toggle_inc = (since_toggle_reg == CNT_MAX) ? since_toggle_reg : since_toggle_reg + 1'b1;
    assign set_code   = (code > PATTERN_LAST) ? PATTERN_CLEARED : code;
    assign sel        = blink_sel(pattern_reg);
    assign blink_mask = blink_led(pattern_reg);

    always_comb
    begin
        case (sel)
            SEL_FAST: interval = intervals.fast_ms;
            SEL_SYNC: interval = intervals.sync_ms;
            SEL_MODE: interval = intervals.mode_ms;
            default:  interval = intervals.slow_ms;
        endcase
    end

    always_comb
    begin
        pattern_next      = pattern_reg;
        hold_next         = hold_reg;
        timed_next        = timed_reg;
        since_start_next  = since_start_reg;
        since_toggle_next = since_toggle_reg;
        phase_next        = phase_reg;
        led_next          = led_reg;
        case (func)
            FUNC_TICK:
            begin
                since_start_next  = start_inc;
                since_toggle_next = toggle_inc;
                if (timed_reg && (start_inc >= {1'b0, hold_reg}))
                begin
                    // hold time ran out
                    pattern_next = PATTERN_CLEARED;
                    timed_next   = 1'b0;
                    led_next     = LED_NONE;
                end
                else if ((sel != SEL_NONE)
                         && (CMP_BITS'(toggle_inc) >= CMP_BITS'(interval)))
                begin
                    since_toggle_next = '0;
                    phase_next        = !phase_reg;
                    led_next          = !phase_reg ? (led_reg | blink_mask)
                                                   : (led_reg & ~blink_mask);
                end
            end
            FUNC_SET:
            begin
                pattern_next      = set_code;
                hold_next         = hold;
                since_start_next  = '0;
                since_toggle_next = '0;
                phase_next        = 1'b1;
                timed_next        = (hold != '0);
                led_next          = start_leds(set_code);
            end
            FUNC_CLEAR:
            begin
                pattern_next = PATTERN_CLEARED;
                timed_next   = 1'b0;
                led_next     = LED_NONE;
            end
            default:
            begin
                pattern_next = pattern_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg      <= PATTERN_CLEARED;
            hold_reg         <= '0;
            timed_reg        <= 1'b0;
            since_start_reg  <= '0;
            since_toggle_reg <= '0;
            phase_reg        <= 1'b0;
            led_reg          <= LED_NONE;
        end
        else if (fire)
        begin
            pattern_reg      <= pattern_next;
            hold_reg         <= hold_next;
            timed_reg        <= timed_next;
            since_start_reg  <= since_start_next;
            since_toggle_reg <= since_toggle_next;
            phase_reg        <= phase_next;
            led_reg          <= led_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_cleared_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (pattern_reg == PATTERN_CLEARED) |-> (led_reg == LED_NONE))
        else $error("cleared pattern with leds lit");

    a_timed_has_hold: assert property (@(posedge clk) disable iff (!rst_n)
        timed_reg |-> (hold_reg != '0))
        else $error("timed pattern with zero hold time");

    a_pattern_range: assert property (@(posedge clk) disable iff (!rst_n)
        !(pattern_reg > PATTERN_LAST))
        else $error("pattern code out of range");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(since_toggle_reg) && $stable(led_reg))
        else $error("state moved without an item");
`endif

endmodule

// ===== hdl/led_status_pattern_controller_core.sv =====
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    func, pattern_code, hold_ms
// out      output     out_valid/out_ready  led_green..led_blue, active_pattern
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle while out_ready does not stall the result; an accepted beat goes through the
// input register, then through next-state logic into the result register
// the state update of the engine sets the pace: one item per state update
// reset is asynchronous, active low; no clearing pass, in_ready is high as soon as reset is released
// a stalled output holds both stages; cfg_ready is always high
module led_status_pattern_controller_core #(
    parameter int unsigned TIME_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [lspc_pkg::CODE_BITS-1:0]      pattern_code,
    input  logic [TIME_BITS-1:0]                hold_ms,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                led_green,
    output logic                                led_yellow,
    output logic                                led_red,
    output logic                                led_blue,
    output logic [lspc_pkg::CODE_BITS-1:0]      active_pattern,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lspc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lspc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import lspc_pkg::*;

    blink_cfg_t intervals;

    logic                 s1_valid_reg;
    logic [1:0]           s1_func_reg;
    logic [CODE_BITS-1:0] s1_code_reg;
    logic [TIME_BITS-1:0] s1_hold_reg;
    logic                 s1_fire;

    logic                 out_valid_reg;
    logic [LED_COUNT-1:0] out_leds_reg;
    logic [CODE_BITS-1:0] out_pattern_reg;

    logic [LED_COUNT-1:0] led_next;
    logic [CODE_BITS-1:0] pattern_next;

    // item in stage 1 moves on when the result slot is free or being emptied
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    lspc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .intervals (intervals)
    );

    lspc_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (s1_fire),
        .func         (s1_func_reg),
        .code         (s1_code_reg),
        .hold         (s1_hold_reg),
        .intervals    (intervals),
        .led_next     (led_next),
        .pattern_next (pattern_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_func_reg <= func;
            s1_code_reg <= pattern_code;
            s1_hold_reg <= hold_ms;
        end
        if (s1_fire)
        begin
            out_leds_reg    <= led_next;
            out_pattern_reg <= pattern_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign led_green      = out_leds_reg[0];
    assign led_yellow     = out_leds_reg[1];
    assign led_red        = out_leds_reg[2];
    assign led_blue       = out_leds_reg[3];
    assign active_pattern = out_pattern_reg;

`ifndef NO_ASSERTIONS
    a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("accepted beat lost before stage 1");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> s1_valid_reg && $stable(s1_func_reg)
                                       && $stable(s1_hold_reg))
        else $error("stalled stage 1 item changed");

    a_result_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("result register not filled");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(out_leds_reg)
                                          && $stable(out_pattern_reg))
        else $error("stalled result changed");
`endif

endmodule
